// ===== rtl/http_header_line_parser_assert.svh =====
// Assertion macros for the header line parser RTL.
`ifndef HTTP_HEADER_LINE_PARSER_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk; hold off while rst is high.
`define HHLP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hhlp assertion failed");

// Check prop at every rising edge of clk, reset cycles included.
`define HHLP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("hhlp assertion failed");

`else

`define HHLP_ASSERT(label, clk, rst, prop)
`define HHLP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/hhlp_pkg.sv =====
`default_nettype none

package hhlp_pkg;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_KEY    = 4'd1,
      PH_COLON  = 4'd2,
      PH_SPACE  = 4'd3,
      PH_VALUE  = 4'd4,
      PH_CR     = 4'd5,
      PH_LF     = 4'd6,
      PH_END_CR = 4'd7,
      PH_END    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_SKIP  = 3'd0,
      KIND_KEY   = 3'd1,
      KIND_VALUE = 3'd2,
      KIND_DELIM = 3'd3,
      KIND_AFTER = 3'd4
   } kind_type;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 10;

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 10'h3FF;
   localparam logic [OFFSET_W-1:0] LIMIT_RESET = 10'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      kind_type          byte_kind;
      logic              pair_done;
      logic              headers_done;
      logic              parse_error;
      phase_type         phase;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/http_header_line_parser.sv =====
// HTTP header line parser.
// Request channel (req_valid/req_ready): one header byte per request in
// req_data_byte; req_restart set clears the parser before that byte.
// Response channel (rsp_valid/rsp_ready): one response per request with the
// echoed byte, its class, the pair-done pulse on the LF that closes a
// key/value line, headers-done, the sticky parse error and the phase.
// csr_wr_en/csr_wr_data write the value length limit; write only while idle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one byte per cycle while rsp_ready is high; each phase update
// is one pass of logic from the state registers to the response register.
// Reset: phase start, offset and error cleared, limit back to 255, response
// register empty.
// Stall: while rsp_ready is low a held response keeps the register full and
// req_ready drops; req_ready stays high in the cycle the response is taken.
`default_nettype none

module http_header_line_parser
   import hhlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_restart,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [BYTE_W-1:0]        rsp_echo_byte,
   output logic [2:0]               rsp_byte_kind,
   output logic                     rsp_pair_done,
   output logic                     rsp_headers_done,
   output logic                     rsp_parse_error,
   output logic [3:0]               rsp_phase,
   input  wire logic                csr_wr_en,
   input  wire logic [OFFSET_W-1:0] csr_wr_data
);

   logic    accept;
   rsp_type result;
   rsp_type rsp_data;

   hhlp_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .restart     (req_restart),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   hhlp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .accept    (accept),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_echo_byte    = rsp_data.echo_byte;
   assign rsp_byte_kind    = rsp_data.byte_kind;
   assign rsp_pair_done    = rsp_data.pair_done;
   assign rsp_headers_done = rsp_data.headers_done;
   assign rsp_parse_error  = rsp_data.parse_error;
   assign rsp_phase        = rsp_data.phase;

endmodule

`default_nettype wire

// ===== rtl/hhlp_fsm.sv =====
`default_nettype none

`include "http_header_line_parser_assert.svh"

module hhlp_fsm
   import hhlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [BYTE_W-1:0]   data_byte,
   input  wire logic                restart,
   input  wire logic                csr_wr_en,
   input  wire logic [OFFSET_W-1:0] csr_wr_data,
   output rsp_type                  result
);

   phase_type             phase_ff, phase_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic                  error_ff, error_in;
   logic [OFFSET_W-1:0]   limit_ff;

   phase_type             cur_phase;
   logic [OFFSET_W-1:0]   cur_offset;
   logic                  cur_error;
   logic [OFFSET_W-1:0]   offset_inc;
   kind_type              kind;
   logic                  pair;
   logic                  bad;
   logic                  is_crlf;

   always_comb begin
      cur_phase  = restart ? PH_START : phase_ff;
      cur_offset = restart ? '0 : offset_ff;
      cur_error  = restart ? 1'b0 : error_ff;
      offset_inc = (cur_offset == OFFSET_MAX) ? cur_offset : cur_offset + 10'd1;
      is_crlf    = (data_byte == CH_CR) || (data_byte == CH_LF);

      kind      = KIND_SKIP;
      pair      = 1'b0;
      bad       = 1'b0;
      phase_in  = cur_phase;
      offset_in = cur_offset;

      if (!cur_error) begin
         unique case (cur_phase)
            PH_KEY: begin
               if (data_byte == CH_COLON) begin
                  kind     = KIND_DELIM;
                  phase_in = PH_COLON;
               end else if (is_crlf) begin
                  bad = 1'b1;
               end else begin
                  kind = KIND_KEY;
               end
            end
            PH_COLON: begin
               if (data_byte == CH_SPACE) begin
                  kind     = KIND_DELIM;
                  phase_in = PH_SPACE;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_SPACE: begin
               kind      = KIND_VALUE;
               offset_in = '0;
               phase_in  = PH_VALUE;
            end
            PH_VALUE: begin
               if (data_byte == CH_CR) begin
                  kind     = KIND_DELIM;
                  phase_in = PH_CR;
               end else begin
                  offset_in = offset_inc;
                  if (offset_inc > limit_ff) begin
                     bad = 1'b1;
                  end else begin
                     kind = KIND_VALUE;
                  end
               end
            end
            PH_CR: begin
               if (data_byte == CH_LF) begin
                  kind     = KIND_DELIM;
                  pair     = 1'b1;
                  phase_in = PH_LF;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_LF: begin
               if (data_byte == CH_CR) begin
                  kind     = KIND_DELIM;
                  phase_in = PH_END_CR;
               end else begin
                  kind     = KIND_KEY;
                  phase_in = PH_KEY;
               end
            end
            PH_END_CR: begin
               if (data_byte == CH_LF) begin
                  kind     = KIND_DELIM;
                  phase_in = PH_END;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_END: begin
               kind = KIND_AFTER;
            end
            default: begin
               if (is_crlf) begin
                  kind     = KIND_SKIP;
                  phase_in = cur_phase;
               end else begin
                  kind     = KIND_KEY;
                  phase_in = PH_KEY;
               end
            end
         endcase
         // drop the class of a failing byte and freeze the phase
         if (bad) begin
            kind     = KIND_SKIP;
            pair     = 1'b0;
            phase_in = cur_phase;
         end
      end

      error_in = cur_error | bad;

      result.echo_byte    = data_byte;
      result.byte_kind    = kind;
      result.pair_done    = pair;
      result.headers_done = (phase_in == PH_END);
      result.parse_error  = error_in;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         offset_ff <= '0;
         error_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         error_ff  <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   `HHLP_ASSERT(a_error_sticky, clock, reset,
      error_ff && !(accept && restart) |=> error_ff)
   `HHLP_ASSERT(a_error_freezes_phase, clock, reset,
      error_ff && accept && !restart |=> phase_ff == $past(phase_ff))
   `HHLP_ASSERT(a_pair_enters_lf, clock, reset,
      accept && result.pair_done |=> phase_ff == PH_LF && !error_ff)

endmodule

`default_nettype wire

// ===== rtl/hhlp_rsp_reg.sv =====
`default_nettype none

`include "http_header_line_parser_assert.svh"

module hhlp_rsp_reg
   import hhlp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      accept,
   input  rsp_type   result,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   always_comb begin
      req_ready    = !rsp_valid_ff || rsp_ready;
      accept       = req_valid && req_ready;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HHLP_ASSERT(a_empty_takes_request, clock, reset,
      !rsp_valid_ff |-> req_ready)
   `HHLP_ASSERT(a_accept_fills, clock, reset,
      accept |=> rsp_valid_ff)
   `HHLP_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> !rsp_valid_ff)

endmodule

`default_nettype wire

// ===== tb/tb_http_header_line_parser.sv =====
`timescale 1ns / 1ps

module tb_http_header_line_parser;
   import hhlp_pkg::*;

   class header_scoreboard;
      phase_type           cur_phase;
      logic [OFFSET_W-1:0] value_offset;
      bit                  error_seen;
      logic [OFFSET_W-1:0] length_limit;
      rsp_type             expected_q[$];
      int unsigned         mismatch_count;
      int unsigned         stray_count;
      int unsigned         checked_count;
      int unsigned         pair_count;
      int unsigned         end_count;
      int unsigned         error_resp_count;

      function new();
         length_limit     = LIMIT_RESET;
         mismatch_count   = 0;
         stray_count      = 0;
         checked_count    = 0;
         pair_count       = 0;
         end_count        = 0;
         error_resp_count = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         cur_phase    = PH_START;
         value_offset = '0;
         error_seen   = 1'b0;
      endfunction

      function void set_limit(logic [OFFSET_W-1:0] limit);
         length_limit = limit;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [BYTE_W-1:0] data, logic restart);
         kind_type kind;
         bit       pair;
         bit       bad;
         rsp_type  want;
         kind = KIND_SKIP;
         pair = 1'b0;
         bad  = 1'b0;
         if (restart)
            clear_parser();
         if (!error_seen) begin
            case (cur_phase)
               PH_KEY: begin
                  if (data == CH_COLON) begin
                     kind      = KIND_DELIM;
                     cur_phase = PH_COLON;
                  end else if (data == CH_CR || data == CH_LF) begin
                     bad = 1'b1;
                  end else begin
                     kind = KIND_KEY;
                  end
               end
               PH_COLON: begin
                  if (data == CH_SPACE) begin
                     kind      = KIND_DELIM;
                     cur_phase = PH_SPACE;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_SPACE: begin
                  kind         = KIND_VALUE;
                  value_offset = '0;
                  cur_phase    = PH_VALUE;
               end
               PH_VALUE: begin
                  if (data == CH_CR) begin
                     kind      = KIND_DELIM;
                     cur_phase = PH_CR;
                  end else begin
                     if (value_offset != OFFSET_MAX)
                        value_offset = value_offset + 1'b1;
                     if (value_offset > length_limit)
                        bad = 1'b1;
                     else
                        kind = KIND_VALUE;
                  end
               end
               PH_CR: begin
                  if (data == CH_LF) begin
                     kind      = KIND_DELIM;
                     pair      = 1'b1;
                     cur_phase = PH_LF;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_LF: begin
                  if (data == CH_CR) begin
                     kind      = KIND_DELIM;
                     cur_phase = PH_END_CR;
                  end else begin
                     kind      = KIND_KEY;
                     cur_phase = PH_KEY;
                  end
               end
               PH_END_CR: begin
                  if (data == CH_LF) begin
                     kind      = KIND_DELIM;
                     cur_phase = PH_END;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_END: begin
                  kind = KIND_AFTER;
               end
               default: begin
                  if (data != CH_CR && data != CH_LF) begin
                     kind      = KIND_KEY;
                     cur_phase = PH_KEY;
                  end
               end
            endcase
            if (bad) begin
               error_seen = 1'b1;
               kind       = KIND_SKIP;
               pair       = 1'b0;
            end
         end
         want.echo_byte    = data;
         want.byte_kind    = kind;
         want.pair_done    = pair;
         want.headers_done = (cur_phase == PH_END);
         want.parse_error  = error_seen;
         want.phase        = cur_phase;
         pair_count       += pair;
         end_count        += (kind == KIND_DELIM && cur_phase == PH_END);
         error_resp_count += error_seen;
         expected_q.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= 10)
               $display("response without a pending request: byte %h", got.echo_byte);
            return;
         end
         want = expected_q.pop_front();
         checked_count++;
         if (got.echo_byte !== want.echo_byte || got.byte_kind !== want.byte_kind ||
             got.pair_done !== want.pair_done || got.headers_done !== want.headers_done ||
             got.parse_error !== want.parse_error || got.phase !== want.phase) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= 10) begin
               $display("mismatch: expected byte %h kind %0d pair %0b done %0b err %0b phase %0d",
                        want.echo_byte, want.byte_kind, want.pair_done, want.headers_done,
                        want.parse_error, want.phase);
               $display("          actual   byte %h kind %0d pair %0b done %0b err %0b phase %0d",
                        got.echo_byte, got.byte_kind, got.pair_done, got.headers_done,
                        got.parse_error, got.phase);
            end
         end
      endfunction
   endclass

   localparam int unsigned ITEM_TARGET = 1400;
   localparam int unsigned NUM_PHASES  = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_echo_byte;
   logic [2:0]          rsp_byte_kind;
   logic                rsp_pair_done;
   logic                rsp_headers_done;
   logic                rsp_parse_error;
   logic [3:0]          rsp_phase;
   logic                csr_wr_en = 1'b0;
   logic [OFFSET_W-1:0] csr_wr_data = '0;

   header_scoreboard sb;
   int unsigned      sent_count = 0;
   int unsigned      rsp_hold = 0;
   bit               gaps_en = 1'b1;
   bit               rsp_stall_en = 1'b1;

   http_header_line_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_echo_byte    (rsp_echo_byte),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_pair_done    (rsp_pair_done),
      .rsp_headers_done (rsp_headers_done),
      .rsp_parse_error  (rsp_parse_error),
      .rsp_phase        (rsp_phase),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 19) < 17)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stall_en && $urandom_range(0, 9) == 0)
            rsp_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data_byte, req_restart);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_type'{echo_byte:    rsp_echo_byte,
                                        byte_kind:    kind_type'(rsp_byte_kind),
                                        pair_done:    rsp_pair_done,
                                        headers_done: rsp_headers_done,
                                        parse_error:  rsp_parse_error,
                                        phase:        phase_type'(rsp_phase)});
      end
   end

   task automatic send_request(logic [BYTE_W-1:0] data, logic restart);
      int unsigned gap;
      gap = 0;
      if (gaps_en && $urandom_range(0, 3) == 0)
         gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_restart   <= restart;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [OFFSET_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(limit);
   endtask

   function automatic logic [BYTE_W-1:0] random_key_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF || b == CH_COLON);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] random_value_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_CR);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] random_special();
      case ($urandom_range(0, 4))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_COLON;
         3: return CH_SPACE;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned pick_value_length();
      int unsigned lim;
      lim = sb.length_limit;
      if ($urandom_range(0, 9) == 0 && lim < 300)
         return lim + $urandom_range(1, 2);
      if (lim <= 64)
         return $urandom_range(1, lim + 3);
      return $urandom_range(1, 12);
   endfunction

   task automatic send_header(int unsigned long_len);
      logic [BYTE_W-1:0] stream[$];
      int unsigned       lines;
      int unsigned       vlen;
      bit                fresh;
      lines = $urandom_range(0, 4);
      if (long_len != 0 && lines == 0)
         lines = 1;
      for (int unsigned ln = 0; ln < lines; ln++) begin
         repeat ($urandom_range(1, 6)) stream.push_back(random_key_byte());
         stream.push_back(CH_COLON);
         stream.push_back(CH_SPACE);
         vlen = (ln == 0 && long_len != 0) ? long_len : pick_value_length();
         repeat (vlen) stream.push_back(random_value_byte());
         stream.push_back(CH_CR);
         stream.push_back(CH_LF);
      end
      stream.push_back(CH_CR);
      stream.push_back(CH_LF);
      repeat ($urandom_range(0, 2)) stream.push_back(BYTE_W'($urandom_range(0, 255)));
      fresh = 1'b1;
      if (long_len == 0) begin
         if ($urandom_range(0, 5) == 0)
            stream[$urandom_range(0, stream.size() - 1)] = random_special();
         fresh = ($urandom_range(0, 7) != 0);
      end
      foreach (stream[i])
         send_request(stream[i], (i == 0) ? fresh : ($urandom_range(0, 299) == 0));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 16))
         send_request(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
   endtask

   initial begin
      #20_000_000;
      $display("[http_header_line_parser] ERROR");
      $finish;
   end

   initial begin
      logic [OFFSET_W-1:0] limits [NUM_PHASES];
      int unsigned         phase_end;
      int unsigned         base_count;
      sb = new();
      limits = '{LIMIT_RESET, 10'd1, 10'd0, OFFSET_MAX, 10'd1022,
                 10'($urandom_range(2, 40)), 10'd7, 10'($urandom_range(41, 300))};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // skip blank lines, take CR as first value byte, LF as key byte, reach end
      send_request(CH_CR, 1'b1);
      send_request(CH_LF, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(CH_COLON, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_COLON, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(CH_COLON, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(8'h80, 1'b0);
      // break the syntax: LF in key, colon without space, bare CR
      send_request(8'h41, 1'b1);
      send_request(CH_LF, 1'b0);
      send_request(CH_COLON, 1'b0);
      send_request(8'h42, 1'b1);
      send_request(CH_COLON, 1'b0);
      send_request(8'h21, 1'b0);
      send_request(8'h43, 1'b1);
      send_request(CH_COLON, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(8'h76, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(8'h55, 1'b0);
      wait_idle();

      base_count = sent_count;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0)
            write_limit(limits[p]);
         gaps_en      = (p % 4) != 3;
         rsp_stall_en = (p % 3) != 2;
         phase_end    = base_count + (p + 1) * ITEM_TARGET / NUM_PHASES;
         while (sent_count < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_header(0);
            if ($urandom_range(0, 19) == 0)
               gaps_en = !gaps_en;
         end
         wait_idle();
      end

      $display("sent %0d request bytes, checked %0d responses across %0d length limits",
               sent_count, sb.checked_count, NUM_PHASES);
      $display("completed pairs %0d, header ends %0d, responses flagged in error %0d",
               sb.pair_count, sb.end_count, sb.error_resp_count);
      if (sb.pending() != 0)
         $display("%0d responses never arrived", sb.pending());
      if (sb.mismatch_count == 0 && sb.stray_count == 0 && sb.pending() == 0) begin
         $display("[http_header_line_parser] OK");
      end else begin
         $display("[http_header_line_parser] ERROR");
      end
      $finish;
   end

endmodule
